FILE: rtl/ip_address_text_validator_core_macros.svh
// Assertion macros for the address text validator RTL.
`ifndef IP_ADDRESS_TEXT_VALIDATOR_CORE_MACROS_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_CORE_MACROS_SVH

// Clocked property, off while in reset.
`define IATV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define IATV_ASSERT_IMP(label, ante, cons, msg) \
	`IATV_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define IATV_ASSERT_NXT(label, ante, cons, msg) \
	`IATV_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: rtl/iatv_pkg.sv
// Types and constants shared by the address text validator modules.
package iatv_pkg;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_V4   = 2'd1,
		KIND_V6   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic       failed;
		logic [2:0] seps;
		logic [2:0] glen;
		logic [8:0] gval;
		logic       glz;
		logic       gdec;
	} scan_state_t;

	localparam logic [8:0] V4_MAX_VALUE  = 9'd255;
	localparam logic [8:0] VALUE_SAT     = 9'd256;
	localparam logic [2:0] V4_MAX_DIGITS = 3'd3;
	localparam logic [2:0] V6_MAX_DIGITS = 3'd4;
	localparam logic [2:0] V4_SEPS       = 3'd3;
	localparam logic [2:0] V6_SEPS       = 3'd7;
	localparam logic [2:0] LEN_SAT       = 3'd5;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	localparam scan_state_t SCAN_CLEAR = '{
		kind:   KIND_NONE,
		failed: 1'b0,
		seps:   3'd0,
		glen:   3'd0,
		gval:   9'd0,
		glz:    1'b0,
		gdec:   1'b1
	};

endpackage

FILE: rtl/ip_address_text_validator_core.sv
// Top level of the IPv4 / IPv6 address text validator.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, symbol, symbol_valid,  | into block
//          | end_of_string                             |
//  out     | out_valid, out_stall, verdict             | out of block
//
// One character item per cycle while in_stall is low; the scan state updates in the cycle it is accepted.
// The verdict of an end-of-string item is registered and shows in the next cycle.
// Reset clears the scan state and drops out_valid; the next string starts fresh.
// in_stall rises only for an end-of-string item while a held verdict is stalled;
// items without end of string keep flowing through a stalled output.
`include "ip_address_text_validator_core_macros.svh"

module ip_address_text_validator_core import iatv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	input  logic       symbol_valid,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] verdict
);

	scan_state_t state_q;
	scan_state_t state_nxt;
	kind_t       verdict_nxt;
	kind_t       verdict_q;
	logic        out_valid_q;
	logic        in_acc;
	logic        out_held;

	iatv_step u_step (
		.cur          (state_q),
		.symbol       (symbol),
		.symbol_valid (symbol_valid),
		.nxt          (state_nxt),
		.verdict      (verdict_nxt)
	);

	assign out_held = out_valid_q && out_stall;
	assign in_stall = out_held && end_of_string;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SCAN_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc)
				state_q <= end_of_string ? SCAN_CLEAR : state_nxt;
			out_valid_q <= (in_acc && end_of_string) || out_held;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && end_of_string)
			verdict_q <= verdict_nxt;
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	`IATV_ASSERT_IMP(a_out_source, out_valid,
		$past(in_valid && !in_stall && end_of_string) || $past(out_valid && out_stall),
		"result without an end-of-string item")
	`IATV_ASSERT_NXT(a_clear_after_eos, in_valid && !in_stall && end_of_string,
		state_q.kind == KIND_NONE && state_q.seps == 3'd0 && !state_q.failed,
		"scan state not cleared after end of string")
	`IATV_ASSERT_IMP(a_no_kind_no_seps, state_q.kind == KIND_NONE, state_q.seps == 3'd0,
		"separators counted with no kind")
	`IATV_ASSERT_IMP(a_v4_sep_limit, state_q.kind == KIND_V4, state_q.seps <= V4_SEPS,
		"IPv4 separator count past limit")

endmodule

FILE: rtl/iatv_step.sv
// Per-character update of the scan state and end-of-string verdict.
module iatv_step import iatv_pkg::*; (
	input  scan_state_t cur,
	input  logic [7:0]  symbol,
	input  logic        symbol_valid,
	output scan_state_t nxt,
	output kind_t       verdict
);

	function automatic logic group_ok(input scan_state_t s, input kind_t k);
		logic ok;
		ok = 1'b0;
		case (k)
			KIND_V4: begin
				ok = (s.glen != 3'd0) && (s.glen <= V4_MAX_DIGITS)
					&& !(s.glz && s.glen > 3'd1) && s.gdec
					&& (s.gval <= V4_MAX_VALUE);
			end
			KIND_V6: begin
				ok = (s.glen != 3'd0) && (s.glen <= V6_MAX_DIGITS);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		return ok;
	endfunction

	logic        is_dot, is_colon, is_dec, is_hexl;
	kind_t       sep_kind;
	logic [2:0]  sep_limit;
	logic [3:0]  digit;
	logic [11:0] val_ext;
	logic [2:0]  need;

	assign is_dot   = (symbol == CH_DOT);
	assign is_colon = (symbol == CH_COLON);
	assign is_dec   = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
	assign is_hexl  = ((symbol >= CH_LA) && (symbol <= CH_LF))
		|| ((symbol >= CH_UA) && (symbol <= CH_UF));
	assign sep_kind  = is_dot ? KIND_V4 : KIND_V6;
	assign sep_limit = is_dot ? V4_SEPS : V6_SEPS;
	assign digit     = 4'(symbol - CH_ZERO);
	// value * 10 + digit, saturated below
	assign val_ext   = 12'({cur.gval, 3'b000}) + 12'({cur.gval, 1'b0}) + 12'(digit);

	always_comb begin
		nxt = cur;
		if (symbol_valid) begin
			if (is_dot || is_colon) begin
				if (cur.kind != KIND_NONE && cur.kind != sep_kind) begin
					nxt.failed = 1'b1;
				end else begin
					nxt.kind = sep_kind;
					if (!group_ok(cur, sep_kind))
						nxt.failed = 1'b1;
					// count stops at the limit
					if (cur.seps >= sep_limit)
						nxt.failed = 1'b1;
					else
						nxt.seps = cur.seps + 3'd1;
				end
				nxt.glen = SCAN_CLEAR.glen;
				nxt.gval = SCAN_CLEAR.gval;
				nxt.glz  = SCAN_CLEAR.glz;
				nxt.gdec = SCAN_CLEAR.gdec;
			end else if (!is_dec && !is_hexl) begin
				nxt.failed = 1'b1;
			end else begin
				if (cur.glen == 3'd0 && symbol == CH_ZERO)
					nxt.glz = 1'b1;
				if (cur.glen < LEN_SAT)
					nxt.glen = cur.glen + 3'd1;
				if (is_dec)
					nxt.gval = (val_ext > 12'(VALUE_SAT)) ? VALUE_SAT : val_ext[8:0];
				else
					nxt.gdec = 1'b0;
			end
		end
	end

	always_comb begin
		need = (nxt.kind == KIND_V4) ? V4_SEPS : V6_SEPS;
		if (nxt.failed || nxt.kind == KIND_NONE || nxt.seps != need
				|| !group_ok(nxt, nxt.kind))
			verdict = KIND_NONE;
		else
			verdict = nxt.kind;
	end

endmodule
